[design/assert_macros.svh]
// assertion macros shared by the frame rate meter modules
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/frm_pkg.sv]
// shared widths, constants and types of the frame rate meter
// no dependencies
`default_nettype none

package frm_pkg;

   localparam int STAMP_W   = 63;
   localparam int REG_W     = 40;
   localparam int RATE_W    = 22;
   localparam int WINDOW    = 32;
   localparam int DIGITS    = 4;
   localparam int FRAC_BITS = 8;
   localparam int POS_W     = $clog2(WINDOW);
   // (WINDOW-1) * ticks_per_second * 2^FRAC_BITS
   localparam int NUM_W     = REG_W + POS_W + FRAC_BITS;
   localparam int CNT_W     = $clog2(NUM_W + 1);
   localparam int CSR_IDX_W = 1;

   localparam logic [RATE_W-1:0] MAX_Q    = RATE_W'((10 ** DIGITS - 1) * (2 ** FRAC_BITS));
   localparam logic [RATE_W-1:0] OFFSET_Q = RATE_W'(77);

   localparam logic [REG_W-1:0] TPS_RESET     = REG_W'(10000000);
   localparam logic [REG_W-1:0] REFRESH_RESET = REG_W'(5000000);

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRESH_TICKS    = 1'b1;

   typedef enum logic [2:0] {
      FRM_IDLE,
      FRM_CHECK,
      FRM_SPAN,
      FRM_DIV,
      FRM_OUT
   } frm_state_type;

   typedef struct packed {
      logic              done;
      logic              ovf;
      logic [RATE_W-1:0] quot;
   } frm_div_res_type;

endpackage

`default_nettype wire

[design/frm_req_if.sv]
// request channel carrying one frame stamp
// depends on frm_pkg
`default_nettype none

interface frm_req_if;
   logic                        valid;
   logic                        ready;
   logic [frm_pkg::STAMP_W-1:0] frame_stamp;

   modport source (output valid, output frame_stamp, input ready);
   modport sink (input valid, input frame_stamp, output ready);
endinterface

`default_nettype wire

[design/frm_rsp_if.sv]
// response channel carrying the displayed rate and the refresh flag
// depends on frm_pkg
`default_nettype none

interface frm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [frm_pkg::RATE_W-1:0] rate_fixed;
   logic                       refreshed;

   modport source (output valid, output rate_fixed, output refreshed, input ready);
   modport sink (input valid, input rate_fixed, input refreshed, output ready);
endinterface

`default_nettype wire

[design/frm_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module frm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/frm_div.sv]
// restoring divider, one quotient bit per cycle, saturation flag for wide quotients
// depends on frm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module frm_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [frm_pkg::NUM_W-1:0]     num,
   input  wire logic [frm_pkg::STAMP_W-1:0]   den,
   output frm_pkg::frm_div_res_type           res
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [frm_pkg::CNT_W-1:0]     cnt_ff;
   logic [frm_pkg::NUM_W-1:0]     num_ff;
   logic [frm_pkg::STAMP_W-1:0]   rem_ff;
   logic [frm_pkg::STAMP_W-1:0]   den_ff;
   logic [frm_pkg::RATE_W-1:0]    quot_ff;
   logic                          ovf_ff;

   logic [frm_pkg::STAMP_W:0]     trial;
   logic [frm_pkg::STAMP_W:0]     trial_sub;
   logic                          ge;
   logic [frm_pkg::STAMP_W-1:0]   rem_in;

   always_comb begin
      trial     = {rem_ff, num_ff[frm_pkg::NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      ge        = (trial >= {1'b0, den_ff});
      // remainder stays below the divisor, so the top bit drops out
      rem_in    = ge ? trial_sub[frm_pkg::STAMP_W-1:0] : trial[frm_pkg::STAMP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= frm_pkg::CNT_W'(frm_pkg::NUM_W);
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            quot_ff <= '0;
            ovf_ff  <= 1'b0;
         end else if (busy_ff) begin
            num_ff  <= {num_ff[frm_pkg::NUM_W-2:0], 1'b0};
            rem_ff  <= rem_in;
            quot_ff <= {quot_ff[frm_pkg::RATE_W-2:0], ge};
            // a one leaving the top means the quotient is beyond the output range
            ovf_ff  <= ovf_ff | quot_ff[frm_pkg::RATE_W-1];
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == frm_pkg::CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      res.done = done_ff;
      res.ovf  = ovf_ff;
      res.quot = quot_ff;
   end

   `ASSERT_IMPLY(a_no_restart, clock, reset, start, !busy_ff, "divider started while busy")
   `ASSERT_IMPLY(a_busy_count, clock, reset, busy_ff, cnt_ff != '0, "divider busy with zero count")

endmodule

`default_nettype wire

[design/frame_rate_meter_top.sv]
// frame rate meter top level: stamp ring, refresh check, rate update and output register
// depends on frm_pkg, frm_req_if, frm_rsp_if, frm_ram, frm_div and assert_macros.svh
// Each request carries one frame stamp and yields exactly one response. Without a refresh
// the request goes from the check state to the output state; with a refresh and a positive
// span the bit-serial divider first steps through all 53 numerator bits, and with a refresh
// but no positive span the held rate is set to the saturated value. The next request is
// taken in the idle state after the response enters the output register, and the output
// register can wait on the receiver. The stamp ring sits in a ram with one write and one
// registered read port.
`default_nettype none
`include "assert_macros.svh"

module frame_rate_meter_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   frm_req_if.sink                              req_chan,
   frm_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_write_en,
   input  wire logic [frm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [frm_pkg::REG_W-1:0]       csr_write_data
);

   frm_pkg::frm_state_type        state_ff, state_in;

   logic [frm_pkg::REG_W-1:0]     tps_ff;
   logic [frm_pkg::REG_W-1:0]     refresh_ff;
   logic [frm_pkg::POS_W-1:0]     pos_ff;
   logic [frm_pkg::POS_W-1:0]     pos_next;
   logic [frm_pkg::WINDOW-1:0]    valid_ff;
   logic                          old_valid_ff;
   logic [frm_pkg::STAMP_W-1:0]   stamp_ff;
   logic [frm_pkg::STAMP_W-1:0]   last_ff;
   logic [frm_pkg::STAMP_W:0]     diff_ff;
   logic [frm_pkg::STAMP_W:0]     span_ff;
   logic [frm_pkg::RATE_W-1:0]    held_ff;
   logic                          refr_ff;
   logic                          rsp_valid_ff;
   logic [frm_pkg::RATE_W-1:0]    rsp_rate_ff;
   logic                          rsp_refr_ff;

   logic                          accept;
   logic                          start_div;
   logic                          load_out;
   logic                          refresh_now;
   logic                          span_pos;
   logic [frm_pkg::STAMP_W-1:0]   rd_data;
   logic [frm_pkg::STAMP_W-1:0]   oldest;
   logic [frm_pkg::NUM_W-1:0]     num;
   logic [frm_pkg::RATE_W-1:0]    q_sat;
   logic [frm_pkg::RATE_W-1:0]    rate_new;
   frm_pkg::frm_div_res_type      div_res;

   assign pos_next = (pos_ff == frm_pkg::POS_W'(frm_pkg::WINDOW - 1)) ? '0 : pos_ff + 1'b1;

   // entries never written read as zero
   assign oldest      = old_valid_ff ? rd_data : '0;
   assign refresh_now = !diff_ff[frm_pkg::STAMP_W] &&
                        (diff_ff[frm_pkg::STAMP_W-1:0] >= frm_pkg::STAMP_W'(refresh_ff));
   assign span_pos    = !span_ff[frm_pkg::STAMP_W] && (span_ff[frm_pkg::STAMP_W-1:0] != '0);
   assign num         = (frm_pkg::NUM_W'(tps_ff) * frm_pkg::NUM_W'(frm_pkg::WINDOW - 1))
                        << frm_pkg::FRAC_BITS;
   assign q_sat       = (div_res.ovf || (div_res.quot > frm_pkg::MAX_Q)) ? frm_pkg::MAX_Q
                                                                        : div_res.quot;
   assign rate_new    = q_sat + frm_pkg::OFFSET_Q;

   frm_ram #(
      .WIDTH (frm_pkg::STAMP_W),
      .DEPTH (frm_pkg::WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos_ff),
      .wr_data (req_chan.frame_stamp),
      .rd_en   (accept),
      .rd_addr (pos_next),
      .rd_data (rd_data)
   );

   frm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (start_div),
      .num   (num),
      .den   (span_ff[frm_pkg::STAMP_W-1:0]),
      .res   (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frm_pkg::FRM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      accept    = 1'b0;
      start_div = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         frm_pkg::FRM_IDLE: begin
            if (req_chan.valid) begin
               accept   = 1'b1;
               state_in = frm_pkg::FRM_CHECK;
            end
         end
         frm_pkg::FRM_CHECK: begin
            state_in = refresh_now ? frm_pkg::FRM_SPAN : frm_pkg::FRM_OUT;
         end
         frm_pkg::FRM_SPAN: begin
            if (span_pos) begin
               start_div = 1'b1;
               state_in  = frm_pkg::FRM_DIV;
            end else begin
               state_in = frm_pkg::FRM_OUT;
            end
         end
         frm_pkg::FRM_DIV: begin
            if (div_res.done) begin
               state_in = frm_pkg::FRM_OUT;
            end
         end
         frm_pkg::FRM_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = frm_pkg::FRM_IDLE;
            end
         end
         default: begin
            state_in = frm_pkg::FRM_IDLE;
         end
      endcase
   end

   // configuration, ring bookkeeping, last refresh stamp, held rate and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= frm_pkg::TPS_RESET;
         refresh_ff   <= frm_pkg::REFRESH_RESET;
         pos_ff       <= '0;
         valid_ff     <= '0;
         last_ff      <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               frm_pkg::CSR_TICKS_PER_SECOND: tps_ff     <= csr_write_data;
               frm_pkg::CSR_REFRESH_TICKS:    refresh_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (accept) begin
            pos_ff           <= pos_next;
            valid_ff[pos_ff] <= 1'b1;
         end
         if ((state_ff == frm_pkg::FRM_CHECK) && refresh_now) begin
            last_ff <= stamp_ff;
         end
         if ((state_ff == frm_pkg::FRM_SPAN) && !span_pos) begin
            held_ff <= frm_pkg::MAX_Q + frm_pkg::OFFSET_Q;
         end
         if ((state_ff == frm_pkg::FRM_DIV) && div_res.done) begin
            held_ff <= rate_new;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request payload, span and refresh flag, and response payload path
   always_ff @(posedge clock) begin
      if (accept) begin
         stamp_ff     <= req_chan.frame_stamp;
         old_valid_ff <= valid_ff[pos_next];
         diff_ff      <= {1'b0, req_chan.frame_stamp} - {1'b0, last_ff};
      end
      if (state_ff == frm_pkg::FRM_CHECK) begin
         span_ff <= {1'b0, stamp_ff} - {1'b0, oldest};
         refr_ff <= refresh_now;
      end
      if (load_out) begin
         rsp_rate_ff <= held_ff;
         rsp_refr_ff <= refr_ff;
      end
   end

   assign req_chan.ready      = (state_ff == frm_pkg::FRM_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.rate_fixed = rsp_rate_ff;
   assign rsp_chan.refreshed  = rsp_refr_ff;

   `ASSERT_ALWAYS(a_pos_range, clock, reset, pos_ff <= frm_pkg::POS_W'(frm_pkg::WINDOW - 1), "ring position beyond window")
   `ASSERT_ALWAYS(a_held_floor, clock, reset, (held_ff == '0) || (held_ff >= frm_pkg::OFFSET_Q), "held rate lacks offset")
   `ASSERT_NEXT(a_div_to_out, clock, reset, (state_ff == frm_pkg::FRM_DIV) && div_res.done, state_ff == frm_pkg::FRM_OUT, "divider result not forwarded")

endmodule

`default_nettype wire
